// ===== hdl/cau_pkg.sv =====
// Shared constants, types and saturation helper for the complex arithmetic unit.
// No dependencies; imported by every cau_* module and the top level.
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    localparam int AW  = DATA_WIDTH + 1;         // add/sub sum
    localparam int PW  = 2 * DATA_WIDTH;         // product, denominator
    localparam int NW  = PW + 1;                 // exact sum of two products
    localparam int MW  = PW;                     // numerator magnitude
    localparam int RW  = PW + 1;                 // partial remainder after shift
    localparam int DVW = MW + FRAC_BITS;         // scaled dividend
    localparam int CW  = 3 * DATA_WIDTH + FRAC_BITS;

    typedef enum logic [1:0] {
        MODE_ADD,
        MODE_SUB,
        MODE_MUL,
        MODE_DIV
    } t_mode;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                         sat;
        logic signed [DATA_WIDTH-1:0] val;
    } t_clamp;

    // products and sums after the multiplier stages
    typedef struct packed {
        logic                  vld;
        t_mode                 mode;
        logic signed [AW-1:0]  as_re;
        logic signed [AW-1:0]  as_im;
        logic signed [NW-1:0]  num_re;
        logic signed [NW-1:0]  num_im;
        logic [PW-1:0]         den;
    } t_prod;

    // word moving through the divider stages; non-divide results ride along
    typedef struct packed {
        logic                         vld;
        logic                         is_div;
        logic                         zero;
        logic                         sat;
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic                         neg_re;
        logic                         neg_im;
        logic                         ovf_re;
        logic                         ovf_im;
        logic [PW-1:0]                den;
        logic [RW-1:0]                r_re;
        logic [RW-1:0]                r_im;
        logic [DATA_WIDTH-1:0]        q_re;
        logic [DATA_WIDTH-1:0]        q_im;
        logic [DATA_WIDTH-1:0]        lo_re;
        logic [DATA_WIDTH-1:0]        lo_im;
    } t_dstage;

    function automatic t_clamp sat_clamp(input logic signed [NW-1:0] x);
        t_clamp c;
        localparam logic signed [NW-1:0] SMAX = {{(NW-DATA_WIDTH+1){1'b0}},
                                                 {(DATA_WIDTH-1){1'b1}}};
        localparam logic signed [NW-1:0] SMIN = {{(NW-DATA_WIDTH+1){1'b1}},
                                                 {(DATA_WIDTH-1){1'b0}}};
        if (x > SMAX) begin
            c.sat = 1'b1;
            c.val = DMAX;
        end else if (x < SMIN) begin
            c.sat = 1'b1;
            c.val = DMIN;
        end else begin
            c.sat = 1'b0;
            c.val = x[DATA_WIDTH-1:0];
        end
        return c;
    endfunction

endpackage

// ===== hdl/cau_mult.sv =====
// Front end: input register with the six products, then mode-dependent
// numerators and |b|^2. Depends on cau_pkg.
module cau_mult import cau_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  t_mode                        i_mode,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output t_prod                        o_prod
);

    logic                 r_vld;
    t_mode                r_mode;
    logic signed [PW-1:0] r_rr, r_ii, r_ri, r_ir, r_sq_r, r_sq_i;
    logic signed [AW-1:0] r_as_re, r_as_im;
    t_prod                r_prod;
    t_prod                n_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_mode <= i_mode;
            r_rr   <= i_a_re * i_b_re;
            r_ii   <= i_a_im * i_b_im;
            r_ri   <= i_a_re * i_b_im;
            r_ir   <= i_a_im * i_b_re;
            r_sq_r <= i_b_re * i_b_re;
            r_sq_i <= i_b_im * i_b_im;
            if (i_mode == MODE_SUB) begin
                r_as_re <= AW'(i_a_re) - AW'(i_b_re);
                r_as_im <= AW'(i_a_im) - AW'(i_b_im);
            end else begin
                r_as_re <= AW'(i_a_re) + AW'(i_b_re);
                r_as_im <= AW'(i_a_im) + AW'(i_b_im);
            end
        end
    end

    always_comb begin
        n_prod       = '0;
        n_prod.vld   = r_vld;
        n_prod.mode  = r_mode;
        n_prod.as_re = r_as_re;
        n_prod.as_im = r_as_im;
        n_prod.den   = $unsigned(r_sq_r) + $unsigned(r_sq_i);
        if (r_mode == MODE_DIV) begin
            // a * conj(b)
            n_prod.num_re = NW'(r_rr) + NW'(r_ii);
            n_prod.num_im = NW'(r_ir) - NW'(r_ri);
        end else begin
            n_prod.num_re = NW'(r_rr) - NW'(r_ii);
            n_prod.num_im = NW'(r_ri) + NW'(r_ir);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.vld <= 1'b0;
        end else if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/cau_div_step.sv =====
// One restoring-division step for both quotient lanes, registered.
// Depends on cau_pkg.
module cau_div_step import cau_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_dstage i_st,
    output t_dstage o_st
);

    t_dstage       r_st;
    t_dstage       n_st;
    logic [RW-1:0] rs_re, rs_im;
    logic          ge_re, ge_im;

    always_comb begin
        n_st  = i_st;
        rs_re = {i_st.r_re[RW-2:0], i_st.lo_re[DATA_WIDTH-1]};
        rs_im = {i_st.r_im[RW-2:0], i_st.lo_im[DATA_WIDTH-1]};
        ge_re = rs_re >= RW'(i_st.den);
        ge_im = rs_im >= RW'(i_st.den);
        n_st.r_re  = ge_re ? rs_re - RW'(i_st.den) : rs_re;
        n_st.r_im  = ge_im ? rs_im - RW'(i_st.den) : rs_im;
        n_st.q_re  = {i_st.q_re[DATA_WIDTH-2:0], ge_re};
        n_st.q_im  = {i_st.q_im[DATA_WIDTH-2:0], ge_im};
        n_st.lo_re = i_st.lo_re << 1;
        n_st.lo_im = i_st.lo_im << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.vld <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

// ===== hdl/complex_arithmetic_unit.sv =====
// Complex add/sub/mul/div on signed fixed point, fully pipelined.
// Pipeline from an accepted word to o_valid: 3 front stages, one divider stage
// per result bit, one output stage.
// Throughput: one word per cycle; a stall at the output freezes every stage.
// Reset clears all valid bits; the pipeline is empty after reset.
// Depends on cau_pkg, cau_mult, cau_div_step.
module complex_arithmetic_unit import cau_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_mode,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_res_re,
    output logic signed [DATA_WIDTH-1:0] o_res_im,
    output logic [1:0]                   o_status
);

    typedef struct packed {
        logic                  neg;
        logic                  ovf;
        logic [RW-1:0]         r;
        logic [DATA_WIDTH-1:0] lo;
    } t_lane;

    logic                         en;
    t_prod                        prod;
    t_dstage                      n_prep;
    t_dstage                      r_prep;
    t_dstage                      w_st [DATA_WIDTH+1];
    t_lane                        ln_re, ln_im;
    t_clamp                       c_re, c_im, f_re, f_im;
    logic                         r_out_vld;
    logic signed [DATA_WIDTH-1:0] r_res_re, r_res_im;
    logic [1:0]                   r_status;
    logic signed [DATA_WIDTH-1:0] n_res_re, n_res_im;
    logic [1:0]                   n_status;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    cau_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_mode  (t_mode'(i_mode)),
        .i_a_re  (i_a_re),
        .i_a_im  (i_a_im),
        .i_b_re  (i_b_re),
        .i_b_im  (i_b_im),
        .o_prod  (prod)
    );

    // sign/magnitude split, overflow test and first remainder of one lane
    function automatic t_lane div_prep(input logic signed [NW-1:0] num,
                                       input logic [PW-1:0] den);
        t_lane          l;
        logic [MW-1:0]  mag;
        logic [DVW-1:0] dvd;
        l.neg = num[NW-1];
        mag   = l.neg ? MW'(-num) : MW'(num);
        // quotient would need more than DATA_WIDTH bits
        l.ovf = (CW'(mag) << FRAC_BITS) >= (CW'(den) << DATA_WIDTH);
        dvd   = DVW'(mag) << FRAC_BITS;
        l.r   = RW'(dvd[DVW-1:DATA_WIDTH]);
        l.lo  = dvd[DATA_WIDTH-1:0];
        return l;
    endfunction

    // clamp an unsigned quotient to the signed range
    function automatic t_clamp div_fin(input logic neg, input logic ovf,
                                       input logic [DATA_WIDTH-1:0] q);
        t_clamp c;
        if (neg) begin
            c.sat = ovf || (q[DATA_WIDTH-1] && (|q[DATA_WIDTH-2:0]));
            c.val = c.sat ? DMIN : -$signed(q);
        end else begin
            c.sat = ovf || q[DATA_WIDTH-1];
            c.val = c.sat ? DMAX : $signed(q);
        end
        return c;
    endfunction

    always_comb begin
        ln_re = div_prep(prod.num_re, prod.den);
        ln_im = div_prep(prod.num_im, prod.den);
        if (prod.mode == MODE_MUL) begin
            c_re = sat_clamp(prod.num_re >>> FRAC_BITS);
            c_im = sat_clamp(prod.num_im >>> FRAC_BITS);
        end else begin
            c_re = sat_clamp(NW'(prod.as_re));
            c_im = sat_clamp(NW'(prod.as_im));
        end
        n_prep        = '0;
        n_prep.vld    = prod.vld;
        n_prep.is_div = prod.mode == MODE_DIV;
        n_prep.zero   = prod.den == '0;
        n_prep.sat    = c_re.sat || c_im.sat;
        n_prep.res_re = c_re.val;
        n_prep.res_im = c_im.val;
        n_prep.neg_re = ln_re.neg;
        n_prep.neg_im = ln_im.neg;
        n_prep.ovf_re = ln_re.ovf;
        n_prep.ovf_im = ln_im.ovf;
        n_prep.den    = prod.den;
        n_prep.r_re   = ln_re.r;
        n_prep.r_im   = ln_im.r;
        n_prep.lo_re  = ln_re.lo;
        n_prep.lo_im  = ln_im.lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.vld <= 1'b0;
        end else if (en) begin
            r_prep <= n_prep;
        end
    end

    assign w_st[0] = r_prep;

    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_st    (w_st[g]),
            .o_st    (w_st[g+1])
        );
    end

    always_comb begin
        f_re = div_fin(w_st[DATA_WIDTH].neg_re, w_st[DATA_WIDTH].ovf_re,
                       w_st[DATA_WIDTH].q_re);
        f_im = div_fin(w_st[DATA_WIDTH].neg_im, w_st[DATA_WIDTH].ovf_im,
                       w_st[DATA_WIDTH].q_im);
        if (!w_st[DATA_WIDTH].is_div) begin
            n_res_re = w_st[DATA_WIDTH].res_re;
            n_res_im = w_st[DATA_WIDTH].res_im;
            n_status = w_st[DATA_WIDTH].sat ? ST_SAT : ST_OK;
        end else if (w_st[DATA_WIDTH].zero) begin
            n_res_re = '0;
            n_res_im = '0;
            n_status = ST_DIV0;
        end else begin
            n_res_re = f_re.val;
            n_res_im = f_im.val;
            n_status = (f_re.sat || f_im.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= w_st[DATA_WIDTH].vld;
        end
        if (en) begin
            r_res_re <= n_res_re;
            r_res_im <= n_res_im;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_res_re = r_res_re;
    assign o_res_im = r_res_im;
    assign o_status = r_status;

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DIV0 |-> o_res_re == '0 && o_res_im == '0)
        else $error("divide-by-zero word with nonzero result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_SAT || o_status == ST_DIV0))
        else $error("undefined status code");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> $stable(w_st[0]) && $stable(w_st[DATA_WIDTH]))
        else $error("pipeline moved during output stall");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SAT |->
            (o_res_re == DMAX || o_res_re == DMIN || o_res_im == DMAX || o_res_im == DMIN))
        else $error("saturated status without a clamped component");

endmodule

// ===== tb/complex_arithmetic_unit_test.sv =====
// Testbench for complex_arithmetic_unit: directed corners, then random words under
// idle, stall and back-pressure patterns, each result checked against a local predictor.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
module complex_arithmetic_unit_test;
    import cau_pkg::*;

    localparam int LATENCY     = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] re;
        logic signed [DATA_WIDTH-1:0] im;
        logic [1:0]                   status;
    } t_cplx_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [1:0]                   i_mode = '0;
    logic signed [DATA_WIDTH-1:0] i_a_re = '0;
    logic signed [DATA_WIDTH-1:0] i_a_im = '0;
    logic signed [DATA_WIDTH-1:0] i_b_re = '0;
    logic signed [DATA_WIDTH-1:0] i_b_im = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0] o_res_re;
    logic signed [DATA_WIDTH-1:0] o_res_im;
    logic [1:0]                   o_status;

    t_cplx_result pending_results[$];
    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    int  hold_cycles   = 0;
    int  cycle_count   = 0;
    bit  failed        = 1'b0;

    complex_arithmetic_unit DUT (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // clamp to the data width; flags saturation
    function automatic logic signed [DATA_WIDTH-1:0] clamp_word(longint v, inout bit sat);
        longint hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
        longint lo = -(longint'(1) <<< (DATA_WIDTH - 1));
        if (v > hi) begin
            sat = 1'b1;
            v = hi;
        end else if (v < lo) begin
            sat = 1'b1;
            v = lo;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    // truncating quotient of num * 2^FRAC_BITS over den
    function automatic longint scaled_quotient(longint num, longint den);
        longint mag = (num < 0) ? -num : num;
        longint q   = (mag <<< FRAC_BITS) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_cplx_result complex_op(t_mode mode, longint ar, longint ai,
                                                longint br, longint bi);
        t_cplx_result r;
        bit     sat = 1'b0;
        longint den;
        case (mode)
            MODE_ADD: begin
                r.re = clamp_word(ar + br, sat);
                r.im = clamp_word(ai + bi, sat);
            end
            MODE_SUB: begin
                r.re = clamp_word(ar - br, sat);
                r.im = clamp_word(ai - bi, sat);
            end
            MODE_MUL: begin
                r.re = clamp_word((ar * br - ai * bi) >>> FRAC_BITS, sat);
                r.im = clamp_word((ar * bi + ai * br) >>> FRAC_BITS, sat);
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.status = ST_DIV0;
                    return r;
                end
                r.re = clamp_word(scaled_quotient(ar * br + ai * bi, den), sat);
                r.im = clamp_word(scaled_quotient(ai * br - ar * bi, den), sat);
            end
        endcase
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic send_word(t_mode mode, logic signed [DATA_WIDTH-1:0] ar,
                             logic signed [DATA_WIDTH-1:0] ai,
                             logic signed [DATA_WIDTH-1:0] br,
                             logic signed [DATA_WIDTH-1:0] bi);
        t_cplx_result exp_r;
        exp_r = complex_op(mode, ar, ai, br, bi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_a_re  <= ar;
        i_a_im  <= ai;
        i_b_re  <= br;
        i_b_im  <= bi;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(exp_r);
    endtask

    task automatic idle_sender();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] rand_operand();
        case ($urandom_range(5))
            0: return DMAX;
            1: return DMIN;
            2: return DATA_WIDTH'($urandom_range(0, 1023) - 512);
            3: return DATA_WIDTH'($urandom_range(0, 15) - 8);
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_random();
        t_mode mode = t_mode'($urandom_range(3));
        logic signed [DATA_WIDTH-1:0] br = rand_operand();
        logic signed [DATA_WIDTH-1:0] bi = rand_operand();
        if (mode == MODE_DIV && $urandom_range(19) == 0) begin
            br = '0;
            bi = '0;
        end
        send_word(mode, rand_operand(), rand_operand(), br, bi);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(MODE_ADD, DMAX, DMAX, DMAX, 16'sd1);
        send_word(MODE_ADD, DMIN, DMIN, DMIN, -16'sd1);
        send_word(MODE_ADD, 16'sd100, -16'sd200, 16'sd300, 16'sd50);
        send_word(MODE_SUB, DMIN, DMAX, DMAX, DMIN);
        send_word(MODE_SUB, 16'sd5, 16'sd0, 16'sd5, 16'sd0);
        send_word(MODE_MUL, DMIN, 16'sd0, DMIN, 16'sd0);
        send_word(MODE_MUL, DMIN, DMIN, DMIN, DMIN);
        send_word(MODE_MUL, DMAX, DMAX, DMAX, DMIN);
        send_word(MODE_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0);   // floor of tiny negative
        send_word(MODE_MUL, 16'sd256, 16'sd256, 16'sd256, -16'sd256);
        send_word(MODE_DIV, 16'sd256, 16'sd0, 16'sd0, 16'sd0);  // zero divisor
        send_word(MODE_DIV, DMAX, DMIN, 16'sd0, 16'sd0);
        send_word(MODE_DIV, DMAX, DMAX, 16'sd1, 16'sd0);
        send_word(MODE_DIV, DMIN, 16'sd0, 16'sd0, -16'sd1);
        send_word(MODE_DIV, 16'sd512, 16'sd256, 16'sd256, 16'sd0);
        send_word(MODE_DIV, -16'sd1, 16'sd0, 16'sd3, 16'sd0);   // truncates toward zero
        send_word(MODE_DIV, 16'sd300, -16'sd700, -16'sd3, 16'sd7);
        send_word(MODE_DIV, DMIN, DMIN, DMIN, DMIN);
        send_word(MODE_DIV, 16'sd1, 16'sd1, DMAX, DMIN);
        idle_sender();
    endtask

    task automatic test_random(int n, int send_idle, int stall);
        send_idle_pct = send_idle;
        stall_pct     = stall;
        repeat (n) send_random();
        idle_sender();
    endtask

    // output held off long enough for the pipeline to fill and stall the input
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 300;
        repeat (80) send_random();
        idle_sender();
    endtask

    task automatic test_pause_until_drained();
        send_idle_pct = 10;
        stall_pct     = 20;
        repeat (30) send_random();
        idle_sender();
        wait_drained();
        repeat (50) send_random();
        idle_sender();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400, 0, 0);
        test_random(400, 45, 0);
        test_random(400, 0, 45);
        test_random(400, 16, 16);
        test_backpressure();
        test_pause_until_drained();
        stall_pct = 10;
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (!failed && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result checker
    always @(posedge i_clk) begin
        t_cplx_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word re=%0d im=%0d status=%0d",
                       o_res_re, o_res_im, o_status);
                failed <= 1'b1;
            end else begin
                e = pending_results.pop_front();
                if (o_res_re !== e.re) begin
                    $error("res_re expected %0d got %0d", e.re, o_res_re);
                    failed <= 1'b1;
                end
                if (o_res_im !== e.im) begin
                    $error("res_im expected %0d got %0d", e.im, o_res_im);
                    failed <= 1'b1;
                end
                if (o_status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, o_status);
                    failed <= 1'b1;
                end
            end
        end
    end

    // receiver stall, with long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end
endmodule
